FILE: rtl/pft_pkg.sv
// Shared constants and types for the polygon fan triangulator.
`timescale 1ns / 1ps
package pft_pkg;

  localparam int INDEX_W    = 17;
  localparam int COORD_W    = 16;
  localparam int POS_W      = 20;
  localparam int FACE_W     = 20;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Separator code in the index stream (-1 in 17 bits).
  localparam logic [INDEX_W-1:0] END_OF_FACE = {INDEX_W{1'b1}};

  // Word index of the winding register.
  localparam logic REG_WINDING = 1'b0;

  // Vertices seen in the open face, saturating at two.
  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [FACE_W-1:0]  face_t;

endpackage

FILE: rtl/pft_if.sv
// Valid/ready channel interfaces for index words and triangle words.
`timescale 1ns / 1ps
interface pft_index_if;
  logic                     valid;
  logic                     ready;
  logic signed [17-1:0]     vertex_index;
  logic                     first_of_mesh;

  modport source (output valid, output vertex_index, output first_of_mesh, input ready);
  modport sink   (input valid, input vertex_index, input first_of_mesh, output ready);
endinterface

interface pft_tri_if;
  logic        valid;
  logic        ready;
  logic [19:0] face_number;
  logic [15:0] corner_a_index;
  logic [15:0] corner_b_index;
  logic [15:0] corner_c_index;
  logic [19:0] corner_a_position;
  logic [19:0] corner_b_position;
  logic [19:0] corner_c_position;

  modport source (
    output valid, input ready,
    output face_number, output corner_a_index, output corner_b_index,
    output corner_c_index, output corner_a_position, output corner_b_position,
    output corner_c_position
  );
  modport sink (
    input valid, output ready,
    input face_number, input corner_a_index, input corner_b_index,
    input corner_c_index, input corner_a_position, input corner_b_position,
    input corner_c_position
  );
endinterface

FILE: rtl/pft_cfg_regs.sv
// APB register file holding the winding control.
`timescale 1ns / 1ps
module pft_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pft_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pft_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pft_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic                           counter_clockwise
);
  import pft_pkg::*;

  logic wr_en;
  logic hit;

  assign hit    = (paddr[2] == REG_WINDING);
  assign wr_en  = psel && penable && pwrite && hit;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_clockwise <= 1'b1;
    end else if (wr_en) begin
      counter_clockwise <= pwdata[0];
    end
  end

  // beyond the register list reads as zero
  assign prdata = hit ? {{(APB_DATA_W-1){1'b0}}, counter_clockwise} : '0;

endmodule

FILE: rtl/polygon_fan_triangulator_core.sv
// Top level: streaming triangle-fan triangulator for polygon index lists.
//
//   port     dir   protocol      word
//   vtx      in    valid/ready   vertex_index, first_of_mesh
//   fan      out   valid/ready   face number, three corner indices and positions
//   apb      in    APB write     winding register (counter_clockwise)
//
// One index word per cycle while fan is not stalled; a triangle reaches fan in the cycle after its accept.
// Face state updates at accept; the only storage on the result side is the
// fan output register, so vtx stays ready while that register is empty or
// being drained in the same cycle.
// rst is synchronous, active high: clears face state, counters and the
// output valid; winding returns to counter-clockwise.
// Position and face counters saturate at min(MAX_INDEX_ENTRIES-1, 2^20-1).
`timescale 1ns / 1ps
module polygon_fan_triangulator_core #(
  parameter int MAX_INDEX_ENTRIES = 1048576
) (
  input  logic                           clk,
  input  logic                           rst,
  pft_index_if.sink                      vtx,
  pft_tri_if.source                      fan,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pft_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pft_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pft_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import pft_pkg::*;

  localparam int   POS_MAX_INT = (1 << POS_W) - 1;
  localparam int   LIMIT_INT   = (MAX_INDEX_ENTRIES - 1 > POS_MAX_INT) ?
                                 POS_MAX_INT : MAX_INDEX_ENTRIES - 1;
  localparam pos_t COUNT_LIMIT = POS_W'(LIMIT_INT);

  logic counter_clockwise;

  pft_cfg_regs u_cfg (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .counter_clockwise (counter_clockwise)
  );

  // face state
  coord_t     first_vertex,      first_vertex_next;
  pos_t       first_position,    first_position_next;
  coord_t     previous_vertex,   previous_vertex_next;
  pos_t       previous_position, previous_position_next;
  logic [1:0] vertices_seen,     vertices_seen_next;
  pos_t       next_position,     next_position_next;
  face_t      face_count,        face_count_next;

  // output register
  logic   out_valid;
  face_t  out_face;
  coord_t out_a_idx, out_b_idx, out_c_idx;
  pos_t   out_a_pos, out_b_pos, out_c_pos;

  logic       accept;
  logic       is_end;
  logic       emit;
  coord_t     cur;
  logic [1:0] seen_eff;
  pos_t       pos_eff;
  face_t      face_eff;
  coord_t     b_idx, c_idx;
  pos_t       b_pos, c_pos;

  assign vtx.ready = !out_valid || fan.ready;
  assign accept    = vtx.valid && vtx.ready;

  always_comb begin
    // first_of_mesh clears the counters and drops any open face
    seen_eff = vtx.first_of_mesh ? SEEN_NONE : vertices_seen;
    pos_eff  = vtx.first_of_mesh ? '0 : next_position;
    face_eff = vtx.first_of_mesh ? '0 : face_count;
    is_end   = ($unsigned(vtx.vertex_index) == END_OF_FACE);
    cur      = vtx.vertex_index[COORD_W-1:0];
    emit     = !is_end && (seen_eff == SEEN_TWO);

    first_vertex_next      = first_vertex;
    first_position_next    = first_position;
    previous_vertex_next   = previous_vertex;
    previous_position_next = previous_position;
    vertices_seen_next     = seen_eff;
    next_position_next     = pos_eff;
    face_count_next        = face_eff;

    if (is_end) begin
      // an empty face changes nothing
      if (seen_eff != SEEN_NONE) begin
        face_count_next    = (face_eff < COUNT_LIMIT) ? face_eff + 1'b1 : COUNT_LIMIT;
        vertices_seen_next = SEEN_NONE;
      end
    end else begin
      unique case (seen_eff)
        SEEN_NONE: begin
          first_vertex_next   = cur;
          first_position_next = pos_eff;
          vertices_seen_next  = SEEN_ONE;
        end
        SEEN_ONE: vertices_seen_next = SEEN_TWO;
        default:  vertices_seen_next = SEEN_TWO;
      endcase
      previous_vertex_next   = cur;
      previous_position_next = pos_eff;
      next_position_next     = (pos_eff < COUNT_LIMIT) ? pos_eff + 1'b1 : COUNT_LIMIT;
    end

    // winding: clockwise swaps the last two corners
    if (counter_clockwise) begin
      b_idx = previous_vertex;
      b_pos = previous_position;
      c_idx = cur;
      c_pos = pos_eff;
    end else begin
      b_idx = cur;
      b_pos = pos_eff;
      c_idx = previous_vertex;
      c_pos = previous_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_vertex      <= '0;
      first_position    <= '0;
      previous_vertex   <= '0;
      previous_position <= '0;
      vertices_seen     <= SEEN_NONE;
      next_position     <= '0;
      face_count        <= '0;
    end else if (accept) begin
      first_vertex      <= first_vertex_next;
      first_position    <= first_position_next;
      previous_vertex   <= previous_vertex_next;
      previous_position <= previous_position_next;
      vertices_seen     <= vertices_seen_next;
      next_position     <= next_position_next;
      face_count        <= face_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (fan.ready) begin
      out_valid <= 1'b0;
    end
  end

  // triangle word; no reset needed
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_face  <= face_eff;
      out_a_idx <= first_vertex;
      out_b_idx <= b_idx;
      out_c_idx <= c_idx;
      out_a_pos <= first_position;
      out_b_pos <= b_pos;
      out_c_pos <= c_pos;
    end
  end

  assign fan.valid             = out_valid;
  assign fan.face_number       = out_face;
  assign fan.corner_a_index    = out_a_idx;
  assign fan.corner_b_index    = out_b_idx;
  assign fan.corner_c_index    = out_c_idx;
  assign fan.corner_a_position = out_a_pos;
  assign fan.corner_b_position = out_b_pos;
  assign fan.corner_c_position = out_c_pos;

endmodule
